[hw/rtl/chrt_pkg.sv]
package chrt_pkg;

  localparam int unsigned BucketCount = 100;
  localparam int unsigned BucketDepthDefault = 8;
  localparam int unsigned KeyWidth = 40;
  localparam int unsigned PayloadWidth = 64;
  localparam int unsigned BucketIdxWidth = 7;

  typedef enum logic [1:0] {
    OpInsert = 2'd0,
    OpRemove = 2'd1,
    OpUpdate = 2'd2,
    OpFind   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StMissing = 2'd1,
    StFull    = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]              operation;
    logic [KeyWidth-1:0]     lookup_key;
    logic [KeyWidth-1:0]     record_key;
    logic [PayloadWidth-1:0] record_payload;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [KeyWidth-1:0]     found_key;
    logic [PayloadWidth-1:0] found_payload;
  } out_item_t;

  // A classified command as it travels from the front end to the back end.
  typedef struct packed {
    op_e                       op;
    logic [BucketIdxWidth-1:0] bucket;
    logic [KeyWidth-1:0]       lookup_key;
    logic [KeyWidth-1:0]       record_key;
    logic [PayloadWidth-1:0]   record_payload;
  } cmd_t;

  // The lead digit times ten plus the tail digit is at most 165, so one
  // conditional subtract of the bucket count reduces it.
  function automatic logic [BucketIdxWidth-1:0] bucket_of(logic [KeyWidth-1:0] key);
    logic [7:0] sum;
    logic [7:0] red;
    sum = {1'b0, key[39:36], 3'b000} + {3'b000, key[39:36], 1'b0} + {4'h0, key[3:0]};
    red = (sum >= 8'(BucketCount)) ? sum - 8'(BucketCount) : sum;
    return red[BucketIdxWidth-1:0];
  endfunction

endpackage

[hw/rtl/chained_hash_record_table.sv]
// Record table keyed by a 10-digit packed BCD phone number, 100 buckets.
// Input channel: in_valid_i, in_stall_o, in_item_i (operation, keys, payload).
// Output channel: out_valid_o, out_stall_i, out_item_o (status, found record).
// One result item is produced for every input item, in order.
// A two-entry queue decouples the hashing front end from the back end,
// which walks one bucket through record memories with a registered read.
// The back end works on one item at a time. An insert reads the bucket
// count and appends the record unless the bucket is full. A find, update
// or remove compares the records of the bucket in turn until one matches;
// a miss compares every record of the bucket, and a remove shifts each
// later record down by one slot.
// After reset the bucket counts are cleared one per cycle, which keeps the
// back end busy until all 100 are cleared; record memories are not cleared.
// When the receiver stalls, the result holds in the output register and
// the back end waits; the queue then fills and in_stall_o rises.
module chained_hash_record_table import chrt_pkg::*; #(
  parameter int unsigned BUCKET_DEPTH = BucketDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic cmd_valid, cmd_stall;
  cmd_t cmd;

  chrt_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .cmd_valid_o(cmd_valid), .cmd_stall_i(cmd_stall), .cmd_o(cmd)
  );

  chrt_back #(.BucketDepth(BUCKET_DEPTH)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_stall_o(cmd_stall), .cmd_i(cmd),
    .out_valid_o, .out_stall_i, .out_item_o
  );

endmodule

[hw/rtl/chrt_ram.sv]
module chrt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hw/rtl/chrt_front.sv]
module chrt_front import chrt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  output logic     cmd_valid_o,
  input  logic     cmd_stall_i,
  output cmd_t     cmd_o
);

  localparam int unsigned QDepth = 2;

  cmd_t       q_mem_q [QDepth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  cmd_t       cmd_new;

  always_comb begin
    cmd_new.op             = op_e'(in_item_i.operation);
    cmd_new.bucket         = (in_item_i.operation == OpInsert) ?
                             bucket_of(in_item_i.record_key) :
                             bucket_of(in_item_i.lookup_key);
    cmd_new.lookup_key     = in_item_i.lookup_key;
    cmd_new.record_key     = in_item_i.record_key;
    cmd_new.record_payload = in_item_i.record_payload;
  end

  assign in_stall_o  = (cnt_q == 2'(QDepth));
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && !cmd_stall_i;
  assign cmd_o       = q_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[hw/rtl/chrt_back.sv]
module chrt_back import chrt_pkg::*; #(
  parameter int unsigned BucketDepth = BucketDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  output logic      cmd_stall_o,
  input  cmd_t      cmd_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned Entries = BucketCount * BucketDepth;
  localparam int unsigned AddrW = $clog2(Entries);
  localparam int unsigned SlotW = 4;

  typedef enum logic [2:0] {
    SClear, SIdle, SRead, SCheck, SShiftRd, SShiftWr, SDone
  } state_e;

  state_e                    state_q;
  cmd_t                      cmd_q;
  logic [BucketIdxWidth-1:0] clr_idx_q;
  logic [SlotW-1:0]          fill_cur, slot_q;
  logic [AddrW-1:0]          base_q;
  logic                      out_valid_q;
  out_item_t                 out_q, res_q;
  logic                      out_load;

  logic                      we;
  logic [AddrW-1:0]          waddr, raddr;
  logic [KeyWidth-1:0]       wkey, rkey;
  logic [PayloadWidth-1:0]   wpay, rpay;

  logic                      fill_we;
  logic [BucketIdxWidth-1:0] fill_waddr, fill_raddr;
  logic [SlotW-1:0]          fill_wdata;

  assign cmd_stall_o = (state_q != SIdle);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign out_load    = (state_q == SDone) && (!out_valid_q || !out_stall_i);

  always_comb begin
    we    = 1'b0;
    waddr = base_q + AddrW'(slot_q);
    wkey  = cmd_q.record_key;
    wpay  = cmd_q.record_payload;
    raddr = base_q + AddrW'(slot_q);
    if (state_q == SShiftRd) begin
      raddr = base_q + AddrW'(slot_q) + AddrW'(1);
    end
    if (state_q == SShiftWr) begin
      we = 1'b1;
      wkey = rkey;
      wpay = rpay;
    end else if (state_q == SRead && cmd_q.op == OpInsert &&
                 32'(fill_cur) < BucketDepth) begin
      we = 1'b1;
      waddr = base_q + AddrW'(fill_cur);
    end else if (state_q == SCheck && cmd_q.op == OpUpdate &&
                 slot_q < fill_cur && rkey == cmd_q.lookup_key) begin
      we = 1'b1;
    end
  end

  // The bucket counts live in a small memory. While idle it reads the bucket
  // of the incoming command, afterwards the bucket of the held command.
  always_comb begin
    fill_we    = 1'b0;
    fill_waddr = cmd_q.bucket;
    fill_wdata = fill_cur + SlotW'(1);
    fill_raddr = (state_q == SIdle) ? cmd_i.bucket : cmd_q.bucket;
    unique case (state_q)
      SClear: begin
        fill_we    = 1'b1;
        fill_waddr = clr_idx_q;
        fill_wdata = '0;
      end
      SRead: begin
        fill_we = (cmd_q.op == OpInsert) && (32'(fill_cur) < BucketDepth);
      end
      SCheck: begin
        fill_we    = (cmd_q.op == OpRemove) && (slot_q < fill_cur) &&
                     (rkey == cmd_q.lookup_key);
        fill_wdata = fill_cur - SlotW'(1);
      end
      default: fill_we = 1'b0;
    endcase
  end

  chrt_ram #(.Width(KeyWidth), .Depth(Entries)) u_keys (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wkey), .raddr_i(raddr), .rdata_o(rkey)
  );

  chrt_ram #(.Width(PayloadWidth), .Depth(Entries)) u_pays (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wpay), .raddr_i(raddr), .rdata_o(rpay)
  );

  chrt_ram #(.Width(SlotW), .Depth(BucketCount)) u_fill (
    .clk_i, .we_i(fill_we), .waddr_i(fill_waddr), .wdata_i(fill_wdata),
    .raddr_i(fill_raddr), .rdata_o(fill_cur)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && cmd_valid_i) begin
      cmd_q  <= cmd_i;
      base_q <= AddrW'(32'(cmd_i.bucket) * BucketDepth);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      clr_idx_q   <= '0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      res_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_q       <= res_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        SClear: begin
          clr_idx_q <= clr_idx_q + BucketIdxWidth'(1);
          if (clr_idx_q == BucketIdxWidth'(BucketCount - 1)) state_q <= SIdle;
        end
        SIdle: begin
          slot_q <= '0;
          res_q  <= '0;
          if (cmd_valid_i) state_q <= SRead;
        end
        SRead: begin
          if (cmd_q.op == OpInsert) begin
            if (32'(fill_cur) >= BucketDepth) begin
              res_q.status <= StFull;
            end
            state_q <= SDone;
          end else begin
            state_q <= SCheck;
          end
        end
        SCheck: begin
          if (slot_q >= fill_cur) begin
            res_q.status <= StMissing;
            state_q <= SDone;
          end else if (rkey == cmd_q.lookup_key) begin
            if (cmd_q.op == OpFind) begin
              res_q   <= '{status: StOk, found_key: rkey, found_payload: rpay};
              state_q <= SDone;
            end else if (cmd_q.op == OpRemove) begin
              state_q <= (slot_q + SlotW'(1) < fill_cur) ? SShiftRd : SDone;
            end else begin
              state_q <= SDone;
            end
          end else begin
            slot_q  <= slot_q + SlotW'(1);
            state_q <= SRead;
          end
        end
        SShiftRd: state_q <= SShiftWr;
        SShiftWr: begin
          slot_q  <= slot_q + SlotW'(1);
          state_q <= (slot_q + SlotW'(2) < fill_cur + SlotW'(1)) ? SShiftRd : SDone;
        end
        SDone: begin
          if (out_load) begin
            state_q <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

endmodule

[hw/rtl/chrt_checker.sv]
module chrt_checker import chrt_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("Stalled result changed.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.status != 2'd3)
    else $error("Illegal status code.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != StOk |->
      out_item_o.found_key == '0 && out_item_o.found_payload == '0)
    else $error("Failed operation returned record data.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({in_stall_o, out_valid_o}))
    else $error("Handshake output is unknown.");

endmodule

bind chained_hash_record_table chrt_checker u_chrt_checker (.*);
